### rtl/pwm_blinker_with_command_byte_macros.svh
// assertion macros used by the pwm blinker rtl
`ifndef PWM_BLINKER_WITH_COMMAND_BYTE_MACROS_SVH
`define PWM_BLINKER_WITH_COMMAND_BYTE_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define PWMB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pwmb: next-cycle check failed");

// consequent must hold in the same cycle as the antecedent
`define PWMB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pwmb: same-cycle check failed");

`endif

### rtl/pwmb_pkg.sv
// types and constants shared by the pwm blinker modules
`default_nettype none

package pwmb_pkg;

   localparam int COUNT_W   = 16;
   localparam int BYTE_W    = 8;
   localparam int BLINK_W   = 7;
   localparam int PRODUCT_W = COUNT_W + BYTE_W;

   localparam logic [COUNT_W-1:0] PERIOD_RESET      = 16'd32768;
   localparam logic [COUNT_W-1:0] OFF_COMPARE_RESET = PERIOD_RESET / 4;
   localparam logic [BLINK_W-1:0] BLINK_MAX         = 7'd127;

   // command byte codes
   localparam logic [BYTE_W-1:0] CODE_CLEAR = 8'd200;
   localparam logic [BYTE_W-1:0] CODE_QUERY = 8'd255;
   localparam logic [BYTE_W-1:0] CODE_ON_A  = 8'd0;
   localparam logic [BYTE_W-1:0] CODE_ON_B  = 8'd100;

   // floor(x / 100) for x < 2**24 as (x * recip) >> 31, exact over that range
   localparam longint unsigned PERCENT    = 100;
   localparam int              DIV_SHIFT  = 31;
   localparam int              RECIP_W    = 25;
   localparam longint unsigned DIV_SCALE  = 64'd1 << DIV_SHIFT;
   localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((DIV_SCALE + PERCENT - 1) / PERCENT);
   localparam int              SCALED_W   = PRODUCT_W + RECIP_W;

   // one registered input beat
   typedef struct packed {
      logic                 is_cmd;
      logic [BYTE_W-1:0]    cmd_byte;
      logic [PRODUCT_W-1:0] product;   // period * cmd_byte
   } item_type;

endpackage

`default_nettype wire

### rtl/pwmb_ingress.sv
// input register, period register and period * byte product
`default_nettype none

module pwmb_ingress
   import pwmb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data,
   input  wire logic               req_tvalid,
   output      logic               req_tready,
   input  wire logic [BYTE_W-1:0]  req_tdata,
   input  wire logic               req_tuser,
   input  wire logic               advance,
   output      logic               item_valid,
   output      item_type           item,
   output      logic [COUNT_W-1:0] period
);

   logic               valid_ff, valid_in;
   item_type           item_ff, item_in;
   logic [COUNT_W-1:0] period_ff, period_in;
   logic               accept;

   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in  = valid_ff;
      item_in   = item_ff;
      period_in = period_ff;
      if (csr_wr_en) begin
         period_in = csr_wr_data;
      end
      if (accept) begin
         valid_in         = 1'b1;
         item_in.is_cmd   = req_tuser;
         item_in.cmd_byte = req_tdata;
         item_in.product  = PRODUCT_W'(req_tdata) * PRODUCT_W'(period_ff);
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         period_ff <= PERIOD_RESET;
      end else begin
         valid_ff  <= valid_in;
         period_ff <= period_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
   assign period     = period_ff;

endmodule

`default_nettype wire

### rtl/pwmb_core.sv
// timer, led and blink count state, doubling as the result register
`default_nettype none
`include "pwm_blinker_with_command_byte_macros.svh"

module pwmb_core
   import pwmb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire item_type           item,
   input  wire logic [COUNT_W-1:0] period,
   output      logic               advance,
   output      logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   output      logic [7:0]         rsp_tdata
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] tick_ff, tick_in;
   logic [COUNT_W-1:0] off_ff, off_in;
   logic               events_ff, events_in;
   logic               led_ff, led_in;
   logic [BLINK_W-1:0] blinks_ff, blinks_in;
   logic [COUNT_W-1:0] tick_next;
   logic [SCALED_W-1:0] scaled;
   logic [COUNT_W-1:0] quotient;
   logic               tick_go;
   logic               force_on_go;
   logic               keep_blinks_go;

   assign advance   = item_valid && (!rsp_valid_ff || rsp_tready);
   assign tick_next = (tick_ff >= period) ? '0 : tick_ff + 16'd1;
   assign scaled    = SCALED_W'(item.product) * SCALED_W'(DIV_RECIP);
   assign quotient  = scaled[DIV_SHIFT +: COUNT_W];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      tick_in      = tick_ff;
      off_in       = off_ff;
      events_in    = events_ff;
      led_in       = led_ff;
      blinks_in    = blinks_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && !item.is_cmd) begin
         tick_in = tick_next;
         if (events_ff) begin
            // on-compare first, off-compare wins when both hit
            if (tick_next == period) begin
               led_in = 1'b1;
               if (blinks_ff != BLINK_MAX) begin
                  blinks_in = blinks_ff + 7'd1;
               end
            end
            if (tick_next == off_ff) begin
               led_in = 1'b0;
            end
         end
      end else if (advance) begin
         unique case (item.cmd_byte) inside
            CODE_CLEAR: begin
               blinks_in = '0;
            end
            CODE_QUERY: begin
            end
            CODE_ON_A, CODE_ON_B: begin
               events_in = 1'b0;
               led_in    = 1'b1;
            end
            default: begin
               off_in    = quotient;
               events_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         off_ff       <= OFF_COMPARE_RESET;
         events_ff    <= 1'b1;
         led_ff       <= 1'b1;
         blinks_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         tick_ff      <= tick_in;
         off_ff       <= off_in;
         events_ff    <= events_in;
         led_ff       <= led_in;
         blinks_ff    <= blinks_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {blinks_ff, led_ff};

   assign tick_go        = advance && !item.is_cmd;
   assign force_on_go    = advance && item.is_cmd &&
                           (item.cmd_byte == CODE_ON_A || item.cmd_byte == CODE_ON_B);
   assign keep_blinks_go = advance && !(item.is_cmd && item.cmd_byte == CODE_CLEAR);

   `PWMB_ASSERT_NEXT(a_force_on, force_on_go, !events_ff && led_ff)
   `PWMB_ASSERT_NEXT(a_led_frozen, tick_go && !events_ff, led_ff == $past(led_ff))
   `PWMB_ASSERT_NEXT(a_blinks_mono, keep_blinks_go, blinks_ff >= $past(blinks_ff))
   `PWMB_ASSERT_NOW(a_tick_step, $past(tick_go), tick_ff == '0 || tick_ff == $past(tick_ff) + 16'd1)

endmodule

`default_nettype wire

### rtl/pwm_blinker_with_command_byte.sv
// top level of the pwm led blinker driven by ticks and command bytes
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+----------------------------------------
//  req     | in  | req_tvalid / req_tready | tdata: command_byte; tuser: command
//  rsp     | out | rsp_tvalid / rsp_tready | tdata: led_on, blink_count[7:1]
//  csr     | in  | csr_wr_en               | csr_wr_data: period_count
//
//  one beat per cycle sustained while rsp_tready is high; a beat's result reaches rsp via the steps below
//  input register: period * byte product formed on the way in
//  state regs: divide by 100 (reciprocal multiply), then timer and led update into state regs
//  reset: synchronous, period 32768, off-compare 8192, led lit, events on, count 0
//  rsp stall holds the result; one more beat is taken into the input register, then
//  req_tready drops until rsp_tready returns
`default_nettype none

module pwm_blinker_with_command_byte
   import pwmb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data,    // period_count
   // input beats
   input  wire logic               req_tvalid,
   output      logic               req_tready,
   input  wire logic [BYTE_W-1:0]  req_tdata,      // [7:0] command_byte
   input  wire logic               req_tuser,      // [0] command: 0 tick, 1 byte
   // result beats
   output      logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   output      logic [7:0]         rsp_tdata       // [0] led_on, [7:1] blink_count
);

   logic               item_valid;
   item_type           item;
   logic [COUNT_W-1:0] period;
   logic               advance;

   // input side: holds one beat and the period register
   pwmb_ingress u_ingress (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .advance     (advance),
      .item_valid  (item_valid),
      .item        (item),
      .period      (period)
   );

   // state update; led and count registers feed rsp_tdata directly
   pwmb_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .period     (period),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
